[src/cba_pkg.sv]
// Shared constants, control word type and microcode table of the contiguous block allocator.
package cba_pkg;

	// table geometry
	localparam int NUM_BLOCKS = 16;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;

	// field widths
	localparam int FSIZE_W    = 24;
	localparam int BSIZE_W    = 21;
	localparam int FRAG_W     = 20;
	localparam int STATUS_W   = 2;
	localparam int PLACE_W    = 4;
	localparam int BCOUNT_W   = 5;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 56;
	localparam int DIV_BIT_W  = $clog2(FSIZE_W);

	localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(4096);
	localparam logic [BSIZE_W-1:0] BSIZE_MAX   = BSIZE_W'(1048576);

	// request kinds
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

	// sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DIV     = 4'd1;
	localparam logic [STEP_W-1:0] STEP_DECIDE  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_ROUTE   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_SCAN    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_SCANEND = 4'd5;
	localparam logic [STEP_W-1:0] STEP_FILL    = 4'd6;
	localparam logic [STEP_W-1:0] STEP_CLEAR   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_DONE    = 4'd8;

	// datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_WAIT    = 4'd0;
	localparam logic [OP_W-1:0] OP_DIV     = 4'd1;
	localparam logic [OP_W-1:0] OP_DECIDE  = 4'd2;
	localparam logic [OP_W-1:0] OP_ROUTE   = 4'd3;
	localparam logic [OP_W-1:0] OP_SCAN    = 4'd4;
	localparam logic [OP_W-1:0] OP_SCANEND = 4'd5;
	localparam logic [OP_W-1:0] OP_FILL    = 4'd6;
	localparam logic [OP_W-1:0] OP_CLEAR   = 4'd7;
	localparam logic [OP_W-1:0] OP_EMIT    = 4'd8;

	// one control word: operation, fall-through step, step taken when the condition holds
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [STEP_W-1:0] next;
		logic [STEP_W-1:0] branch;
	} ctrl_word_t;

	// microcode table
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		unique case (step)
			STEP_IDLE:    w = '{OP_WAIT,    STEP_IDLE,    STEP_DIV};
			STEP_DIV:     w = '{OP_DIV,     STEP_DIV,     STEP_DECIDE};
			STEP_DECIDE:  w = '{OP_DECIDE,  STEP_ROUTE,   STEP_DONE};
			STEP_ROUTE:   w = '{OP_ROUTE,   STEP_SCAN,    STEP_CLEAR};
			STEP_SCAN:    w = '{OP_SCAN,    STEP_SCAN,    STEP_SCANEND};
			STEP_SCANEND: w = '{OP_SCANEND, STEP_FILL,    STEP_DONE};
			STEP_FILL:    w = '{OP_FILL,    STEP_FILL,    STEP_DONE};
			STEP_CLEAR:   w = '{OP_CLEAR,   STEP_CLEAR,   STEP_DONE};
			STEP_DONE:    w = '{OP_EMIT,    STEP_DONE,    STEP_IDLE};
			default:      w = '{OP_WAIT,    STEP_IDLE,    STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

[src/contiguous_block_allocator.sv]
// Top level of the first-fit contiguous block allocator, run by a microcoded sequencer.
//
//  channel   | direction | handshake         | word
//  ----------+-----------+-------------------+-----------------------------------------------
//  s_*       | in        | s_tvalid/s_tready | tuser: func; tdata: file_size, start_block
//  m_*       | out       | m_tvalid/m_tready | tuser: status; tdata: placed, count, tail used/frag
//  cfg_*     | in        | cfg_wen           | block_size
//
//  One request at a time. From one accept to the next: restoring divider (one quotient bit
//  per cycle), decide, route, first-fit scan from block 0 (one block per cycle), scan end,
//  fill or clear block by block, emit and idle. A zero size, a count past the table or a
//  freed run past the table end skips route, scan, fill and clear. A waiting result sits
//  in the output register, so the next request is still taken; only its emit step waits
//  for the register to empty.
//  Reset clears the block map at once; no clearing pass.
module contiguous_block_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	// tuser: func
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic                                s_tuser,
	// tdata: file_size[23:0], start_block[27:24], zero pad[31:28]
	input  logic [cba_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tuser: status
	output logic [cba_pkg::STATUS_W-1:0]        m_tuser,
	// tdata: placed_block[3:0], block_count[8:4], tail_used[29:9],
	//        tail_fragmented[49:30], zero pad[55:50]
	output logic [cba_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                cfg_wen,
	input  logic [cba_pkg::BSIZE_W-1:0]         cfg_wdata
);

	localparam int IDX_W = cba_pkg::IDX_W;
	localparam int CNT_W = cba_pkg::CNT_W;

	// control state
	logic [cba_pkg::STEP_W-1:0]     step_q;
	logic [cba_pkg::NUM_BLOCKS-1:0] busy_q;
	logic                           out_valid_q;
	logic [cba_pkg::BSIZE_W-1:0]    bsize_q;

	// working registers
	logic                           func_q;
	logic                           zero_q;
	logic [IDX_W-1:0]               start_q;
	logic [cba_pkg::FSIZE_W-1:0]    quo_q;
	logic [cba_pkg::BSIZE_W-1:0]    rmd_q;
	logic [cba_pkg::DIV_BIT_W-1:0]  bit_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               rem_q;
	logic [CNT_W-1:0]               run_q;
	logic [IDX_W-1:0]               idx_q;
	logic [IDX_W-1:0]               place_q;
	logic [cba_pkg::STATUS_W-1:0]   status_q;
	logic [cba_pkg::BSIZE_W-1:0]    tu_q;
	logic [cba_pkg::FRAG_W-1:0]     tf_q;

	// output register
	logic [cba_pkg::STATUS_W-1:0]   out_status_q;
	logic [cba_pkg::PLACE_W-1:0]    out_place_q;
	logic [cba_pkg::BCOUNT_W-1:0]   out_cnt_q;
	logic [cba_pkg::BSIZE_W-1:0]    out_tu_q;
	logic [cba_pkg::FRAG_W-1:0]     out_tf_q;

	cba_pkg::ctrl_word_t            cw;
	logic                           cond;
	logic                           in_acc;
	logic                           out_free;
	logic [cba_pkg::BSIZE_W-1:0]    eff_bs;
	logic [cba_pkg::BSIZE_W:0]      rshift;
	logic                           ge;
	logic [cba_pkg::BSIZE_W-1:0]    rmd_next;
	logic [cba_pkg::FSIZE_W:0]      count_full;
	logic [cba_pkg::FSIZE_W:0]      free_end;
	logic [cba_pkg::BSIZE_W-1:0]    tail_used;
	logic [cba_pkg::FRAG_W-1:0]     tail_frag;
	logic [cba_pkg::STATUS_W-1:0]   dec_status;
	logic                           blk_free;
	logic [CNT_W-1:0]               run_next;
	logic                           found;
	logic                           at_last;
	logic [IDX_W-1:0]               run_start;

	assign cw       = cba_pkg::ucode(step_q);
	assign s_tready = (step_q == cba_pkg::STEP_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// clamp the block size into its legal range
	always_comb begin
		priority if (bsize_q == '0) begin
			eff_bs = cba_pkg::BSIZE_W'(1);
		end else if (bsize_q > cba_pkg::BSIZE_MAX) begin
			eff_bs = cba_pkg::BSIZE_MAX;
		end else begin
			eff_bs = bsize_q;
		end
	end

	// one restoring division step
	assign rshift   = {rmd_q, quo_q[cba_pkg::FSIZE_W-1]};
	assign ge       = (rshift >= {1'b0, eff_bs});
	assign rmd_next = ge ? cba_pkg::BSIZE_W'(rshift - {1'b0, eff_bs})
	                     : rshift[cba_pkg::BSIZE_W-1:0];

	// ceiling count, tail bytes and request status
	assign count_full = {1'b0, quo_q} + (cba_pkg::FSIZE_W+1)'(rmd_q != '0);
	assign free_end   = (cba_pkg::FSIZE_W+1)'(start_q) + count_full;
	assign tail_used  = (rmd_q == '0) ? eff_bs : rmd_q;
	assign tail_frag  = cba_pkg::FRAG_W'(eff_bs - tail_used);

	always_comb begin
		priority if (zero_q) begin
			dec_status = cba_pkg::ST_ZERO;
		end else if (func_q == cba_pkg::FUNC_FREE) begin
			dec_status = (free_end > (cba_pkg::FSIZE_W+1)'(cba_pkg::NUM_BLOCKS))
			             ? cba_pkg::ST_RANGE : cba_pkg::ST_OK;
		end else begin
			dec_status = (count_full > (cba_pkg::FSIZE_W+1)'(cba_pkg::NUM_BLOCKS))
			             ? cba_pkg::ST_NOSPACE : cba_pkg::ST_OK;
		end
	end

	// first-fit scan over one block
	assign blk_free  = !busy_q[idx_q];
	assign run_next  = blk_free ? run_q + CNT_W'(1) : '0;
	assign found     = (run_next == cnt_q);
	assign at_last   = (idx_q == IDX_W'(cba_pkg::NUM_BLOCKS - 1));
	assign run_start = IDX_W'(({1'b0, idx_q} + CNT_W'(1)) - cnt_q);

	// jump condition of the current control word
	always_comb begin
		unique case (cw.op)
			cba_pkg::OP_WAIT:    cond = in_acc;
			cba_pkg::OP_DIV:     cond = (bit_q == '0);
			cba_pkg::OP_DECIDE:  cond = (dec_status != cba_pkg::ST_OK);
			cba_pkg::OP_ROUTE:   cond = (func_q == cba_pkg::FUNC_FREE);
			cba_pkg::OP_SCAN:    cond = found || at_last;
			cba_pkg::OP_SCANEND: cond = (status_q != cba_pkg::ST_OK);
			cba_pkg::OP_FILL:    cond = (rem_q == CNT_W'(1));
			cba_pkg::OP_CLEAR:   cond = (rem_q == CNT_W'(1));
			cba_pkg::OP_EMIT:    cond = out_free;
			default:             cond = 1'b0;
		endcase
	end

	// advance the step counter, update the block map, config and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= cba_pkg::STEP_IDLE;
			busy_q      <= '0;
			out_valid_q <= 1'b0;
			bsize_q     <= cba_pkg::BSIZE_RESET;
		end else begin
			step_q <= cond ? cw.branch : cw.next;
			if (cfg_wen) begin
				bsize_q <= cfg_wdata;
			end
			if (cw.op == cba_pkg::OP_FILL) begin
				busy_q[idx_q] <= 1'b1;
			end else if (cw.op == cba_pkg::OP_CLEAR) begin
				busy_q[idx_q] <= 1'b0;
			end
			if (cw.op == cba_pkg::OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath driven by the control word
	always_ff @(posedge clk) begin
		unique case (cw.op)
			cba_pkg::OP_WAIT: begin
				if (in_acc) begin
					func_q  <= s_tuser;
					zero_q  <= (s_tdata[cba_pkg::FSIZE_W-1:0] == '0);
					start_q <= s_tdata[cba_pkg::FSIZE_W +: IDX_W];
					quo_q   <= s_tdata[cba_pkg::FSIZE_W-1:0];
					rmd_q   <= '0;
					bit_q   <= cba_pkg::DIV_BIT_W'(cba_pkg::FSIZE_W - 1);
				end
			end
			cba_pkg::OP_DIV: begin
				rmd_q <= rmd_next;
				quo_q <= {quo_q[cba_pkg::FSIZE_W-2:0], ge};
				bit_q <= bit_q - cba_pkg::DIV_BIT_W'(1);
			end
			cba_pkg::OP_DECIDE: begin
				status_q <= dec_status;
				cnt_q    <= CNT_W'(count_full);
				rem_q    <= CNT_W'(count_full);
				tu_q     <= tail_used;
				tf_q     <= tail_frag;
				run_q    <= '0;
				place_q  <= start_q;
				idx_q    <= (func_q == cba_pkg::FUNC_FREE) ? start_q : '0;
			end
			cba_pkg::OP_ROUTE: begin
			end
			cba_pkg::OP_SCAN: begin
				run_q <= run_next;
				priority if (found) begin
					place_q <= run_start;
					idx_q   <= run_start;
				end else if (at_last) begin
					status_q <= cba_pkg::ST_NOSPACE;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			cba_pkg::OP_SCANEND: begin
			end
			cba_pkg::OP_FILL, cba_pkg::OP_CLEAR: begin
				idx_q <= idx_q + IDX_W'(1);
				rem_q <= rem_q - CNT_W'(1);
			end
			cba_pkg::OP_EMIT: begin
				if (out_free) begin
					out_status_q <= status_q;
					if (status_q == cba_pkg::ST_OK) begin
						out_place_q <= cba_pkg::PLACE_W'(place_q);
						out_cnt_q   <= cba_pkg::BCOUNT_W'(cnt_q);
					end else begin
						out_place_q <= '0;
						out_cnt_q   <= '0;
					end
					if (status_q == cba_pkg::ST_OK && func_q == cba_pkg::FUNC_ALLOC) begin
						out_tu_q <= tu_q;
						out_tf_q <= tf_q;
					end else begin
						out_tu_q <= '0;
						out_tf_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// drive the result port
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_tf_q, out_tu_q, out_cnt_q, out_place_q};

endmodule

[src/cba_checker.sv]
// Port-level checks of the contiguous block allocator and their binding to the top level.
module cba_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cba_pkg::STATUS_W-1:0]   m_tuser,
	input logic [cba_pkg::M_TDATA_W-1:0]  m_tdata
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// drop to busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one still in work");

	// zero every payload field of a failed request
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cba_pkg::ST_OK |-> m_tdata == '0)
		else $error("failed request carries nonzero payload");

	// a placed run always spans at least one block, at most the table
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cba_pkg::ST_OK |->
		m_tdata[8:4] != '0 && m_tdata[8:4] <= 5'(cba_pkg::NUM_BLOCKS))
		else $error("successful result with bad block count");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
// Self-checking testbench of the contiguous block allocator: streamed requests, predicted placements.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              WATCHDOG_LIMIT = 3000;
	localparam int              SETTLE_CYCLES  = 70;
	localparam longint unsigned FSIZE_LIMIT    = 64'hFF_FFFF;

	// one result word, fields from the highest bit down
	typedef struct packed {
		logic [cba_pkg::STATUS_W-1:0] status;
		logic [cba_pkg::PLACE_W-1:0]  placed;
		logic [cba_pkg::BCOUNT_W-1:0] count;
		logic [cba_pkg::BSIZE_W-1:0]  tail_used;
		logic [cba_pkg::FRAG_W-1:0]   tail_frag;
	} placement_t;

	// a file that currently sits in the table
	typedef struct {
		int unsigned first_blk;
		int unsigned bytes;
		int unsigned blocks;
	} file_rec_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic                           s_tuser;
	logic [cba_pkg::S_TDATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [cba_pkg::STATUS_W-1:0]   m_tuser;
	logic [cba_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                           cfg_wen;
	logic [cba_pkg::BSIZE_W-1:0]    cfg_wdata;

	// shadow of the block map and of the block size register
	logic [cba_pkg::BSIZE_W-1:0]    blk_used   [cba_pkg::NUM_BLOCKS] = '{default: '0};
	logic [cba_pkg::FRAG_W-1:0]     blk_wasted [cba_pkg::NUM_BLOCKS] = '{default: '0};
	logic [cba_pkg::BSIZE_W-1:0]    cfg_block_size = cba_pkg::BSIZE_RESET;

	placement_t            pending_placements[$];
	file_rec_t             live_files[$];
	int unsigned           mismatch_count = 0;
	int unsigned           quiet_cycles   = 0;
	int unsigned           idle_pct       = 20;
	int unsigned           rx_hold_cycles = 0;

	contiguous_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// block size as the allocator applies it
	function automatic longint unsigned eff_block_size();
		if (cfg_block_size == '0) return 64'd1;
		if (cfg_block_size > cba_pkg::BSIZE_MAX) return 64'(cba_pkg::BSIZE_MAX);
		return 64'(cfg_block_size);
	endfunction

	// place or release a file in the shadow map and work out the result word
	function automatic placement_t place_request(input logic func,
			input logic [cba_pkg::FSIZE_W-1:0] fsize,
			input logic [cba_pkg::PLACE_W-1:0] first);
		placement_t      res;
		longint unsigned bs, blocks, tail;
		int              i, k, place;
		bit              found, run_free;
		res = '0;
		bs  = eff_block_size();
		if (fsize == '0) begin
			res.status = cba_pkg::ST_ZERO;
			return res;
		end
		blocks = (64'(fsize) + bs - 64'd1) / bs;
		if (func == cba_pkg::FUNC_ALLOC) begin
			found = 1'b0;
			place = 0;
			// first fit: lowest run of free blocks
			if (blocks <= cba_pkg::NUM_BLOCKS) begin
				for (i = 0; i + blocks <= cba_pkg::NUM_BLOCKS && !found; i++) begin
					run_free = 1'b1;
					for (k = 0; k < blocks; k++)
						if (blk_used[i + k] != '0) run_free = 1'b0;
					if (run_free) begin
						found = 1'b1;
						place = i;
					end
				end
			end
			if (!found) begin
				res.status = cba_pkg::ST_NOSPACE;
				return res;
			end
			tail = 64'(fsize) - bs * (blocks - 64'd1);
			for (k = 0; k < blocks - 1; k++) begin
				blk_used[place + k]   = cba_pkg::BSIZE_W'(bs);
				blk_wasted[place + k] = '0;
			end
			blk_used[place + blocks - 1]   = cba_pkg::BSIZE_W'(tail);
			blk_wasted[place + blocks - 1] = cba_pkg::FRAG_W'(bs - tail);
			res.status    = cba_pkg::ST_OK;
			res.placed    = cba_pkg::PLACE_W'(place);
			res.count     = cba_pkg::BCOUNT_W'(blocks);
			res.tail_used = cba_pkg::BSIZE_W'(tail);
			res.tail_frag = cba_pkg::FRAG_W'(bs - tail);
			return res;
		end
		if (64'(first) + blocks > cba_pkg::NUM_BLOCKS) begin
			res.status = cba_pkg::ST_RANGE;
			return res;
		end
		// clear the run whether or not it was in use
		for (k = 0; k < blocks; k++) begin
			blk_used[first + k]   = '0;
			blk_wasted[first + k] = '0;
		end
		res.status = cba_pkg::ST_OK;
		res.placed = first;
		res.count  = cba_pkg::BCOUNT_W'(blocks);
		return res;
	endfunction

	// offer one request word, predict it on acceptance, then maybe idle
	task automatic issue_request(input logic func, input logic [cba_pkg::FSIZE_W-1:0] fsize,
			input logic [cba_pkg::PLACE_W-1:0] first);
		placement_t res;
		int         i;
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(cba_pkg::S_TDATA_W - cba_pkg::FSIZE_W - cba_pkg::PLACE_W){1'b0}},
			first, fsize};
		do @(posedge clk); while (!s_tready);
		res = place_request(func, fsize, first);
		pending_placements.push_back(res);
		// track live files: add placed ones, drop any that a free touched
		if (res.status == cba_pkg::ST_OK) begin
			if (func == cba_pkg::FUNC_ALLOC) begin
				live_files.push_back(file_rec_t'{32'(res.placed), 32'(fsize), 32'(res.count)});
			end else begin
				for (i = live_files.size() - 1; i >= 0; i--)
					if (live_files[i].first_blk < res.placed + res.count &&
							res.placed < live_files[i].first_blk + live_files[i].blocks)
						live_files.delete(i);
			end
		end
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// drop valid, wait for every outstanding result, then let the block settle
	task automatic drain_requests(input int settle);
		s_tvalid <= 1'b0;
		while (pending_placements.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_block_size(input logic [cba_pkg::BSIZE_W-1:0] value);
		drain_requests(SETTLE_CYCLES);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen        <= 1'b0;
		cfg_block_size  = value;
	endtask

	// free every live file by its own run, then sweep the whole table
	task automatic release_all_files();
		file_rec_t       f;
		longint unsigned span;
		while (live_files.size() != 0) begin
			f = live_files[$urandom_range(0, live_files.size() - 1)];
			issue_request(cba_pkg::FUNC_FREE, cba_pkg::FSIZE_W'(f.bytes),
				cba_pkg::PLACE_W'(f.first_blk));
		end
		span = 64'(cba_pkg::NUM_BLOCKS) * eff_block_size();
		if (span > FSIZE_LIMIT) span = FSIZE_LIMIT;
		issue_request(cba_pkg::FUNC_FREE, cba_pkg::FSIZE_W'(span), '0);
	endtask

	// mostly alloc/free of real files, the rest zero sizes, wild sizes and stray frees
	task automatic random_request();
		longint unsigned bs, sz;
		int unsigned     pick;
		file_rec_t       f;
		bs   = eff_block_size();
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if (live_files.size() != 0 &&
					($urandom_range(0, 2) == 0 || live_files.size() > 5)) begin
				f = live_files[$urandom_range(0, live_files.size() - 1)];
				issue_request(cba_pkg::FUNC_FREE, cba_pkg::FSIZE_W'(f.bytes),
					cba_pkg::PLACE_W'(f.first_blk));
			end else begin
				sz = (($urandom_range(0, 3) == 0) ? $urandom_range(1, cba_pkg::NUM_BLOCKS) :
						$urandom_range(1, 4)) * bs - $urandom_range(0, 32'(bs - 64'd1));
				if (sz > FSIZE_LIMIT) sz = FSIZE_LIMIT;
				issue_request(cba_pkg::FUNC_ALLOC, cba_pkg::FSIZE_W'(sz),
					cba_pkg::PLACE_W'($urandom()));
			end
		end else if (pick < 78) begin
			issue_request(1'($urandom()), '0, cba_pkg::PLACE_W'($urandom()));
		end else if (pick < 90) begin
			issue_request(1'($urandom()), cba_pkg::FSIZE_W'($urandom()),
				cba_pkg::PLACE_W'($urandom()));
		end else begin
			sz = $urandom_range(1, 4) * bs - $urandom_range(0, 32'(bs - 64'd1));
			if (sz > FSIZE_LIMIT) sz = FSIZE_LIMIT;
			issue_request(cba_pkg::FUNC_FREE, cba_pkg::FSIZE_W'(sz),
				cba_pkg::PLACE_W'($urandom()));
		end
	endtask

	task automatic test_directed_cases();
		// zero size on both request kinds
		issue_request(cba_pkg::FUNC_ALLOC, '0, '0);
		issue_request(cba_pkg::FUNC_FREE, '0, 4'hF);
		// partial block, exact block, one byte over a block (start field ignored)
		issue_request(cba_pkg::FUNC_ALLOC, 24'd1, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd4096, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd4097, 4'hF);
		// count far beyond the table, then a full-table file with no room
		issue_request(cba_pkg::FUNC_ALLOC, 24'hFF_FFFF, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd65536, '0);
		// free past the end, then free of a block never used
		issue_request(cba_pkg::FUNC_FREE, 24'd8192, 4'd15);
		issue_request(cba_pkg::FUNC_FREE, 24'd1, 4'd15);
		// run that ends on the last block
		issue_request(cba_pkg::FUNC_ALLOC, 24'd49152, '0);
		// one-block hole: too small for two blocks, fits one
		issue_request(cba_pkg::FUNC_FREE, 24'd4096, 4'd1);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd8192, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd100, '0);
		// clear all, fill with one file, frees one block past and far past the end, clear again
		issue_request(cba_pkg::FUNC_FREE, 24'd65536, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd65536, '0);
		issue_request(cba_pkg::FUNC_FREE, 24'd65537, '0);
		issue_request(cba_pkg::FUNC_FREE, 24'hFF_FFFF, '0);
		issue_request(cba_pkg::FUNC_FREE, 24'd65536, '0);
		// block size zero acts as one byte
		write_block_size('0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd16, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd1, '0);
		issue_request(cba_pkg::FUNC_FREE, 24'd16, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd17, '0);
		// oversized block size clips to the maximum
		write_block_size('1);
		issue_request(cba_pkg::FUNC_ALLOC, 24'hFF_FFFF, '0);
		issue_request(cba_pkg::FUNC_ALLOC, 24'd1048576, '0);
		release_all_files();
	endtask

	task automatic test_block_size_sweep();
		logic [cba_pkg::BSIZE_W-1:0] sizes [8];
		int                          p, n;
		sizes[0] = cba_pkg::BSIZE_W'(1);
		sizes[1] = cba_pkg::BSIZE_MAX;
		sizes[2] = cba_pkg::BSIZE_RESET;
		sizes[3] = cba_pkg::BSIZE_W'($urandom_range(2, 100));
		sizes[4] = cba_pkg::BSIZE_W'($urandom_range(1, 2097151));
		sizes[5] = cba_pkg::BSIZE_W'(1000);
		sizes[6] = cba_pkg::BSIZE_W'($urandom_range(100000, 1048576));
		sizes[7] = cba_pkg::BSIZE_W'($urandom_range(101, 5000));
		for (p = 0; p < 8; p++) begin
			write_block_size(sizes[p]);
			idle_pct = (p % 3 == 2) ? 0 : 20;
			for (n = 0; n < 140; n++) random_request();
			release_all_files();
		end
		idle_pct = 20;
	endtask

	// stall the result side long enough that the input backs up
	task automatic test_backpressure();
		int n;
		write_block_size(cba_pkg::BSIZE_W'(512));
		idle_pct       = 0;
		rx_hold_cycles = 400;
		for (n = 0; n < 20; n++) random_request();
		release_all_files();
		idle_pct = 20;
	endtask

	// back-to-back traffic with both sides always ready
	task automatic test_steady_stream();
		int n;
		write_block_size(cba_pkg::BSIZE_W'($urandom_range(1, 8192)));
		idle_pct = 0;
		for (n = 0; n < 180; n++) random_request();
		release_all_files();
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= 1'b0;
		s_tdata   <= '0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_block_size_sweep();
		test_backpressure();
		test_steady_stream();
		drain_requests(100);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// result side: random stall bursts, or one long hold when asked
	initial begin : drive_ready
		int unsigned hold;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles != 0) begin
				hold           = rx_hold_cycles;
				rx_hold_cycles = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each result word with the oldest predicted placement
	always @(posedge clk) begin : check_placement
		placement_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[3:0], m_tdata[8:4], m_tdata[29:9], m_tdata[49:30]};
			if (pending_placements.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR %0t: result word with none pending: status=%0d tdata=%h",
						$realtime, m_tuser, m_tdata);
			end else begin
				want = pending_placements.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("ERROR %0t: expected status %0d block %0d count %0d used %0d frag %0d",
							$realtime, want.status, want.placed, want.count,
							want.tail_used, want.tail_frag);
						$display("ERROR %0t: actual   status %0d block %0d count %0d used %0d frag %0d",
							$realtime, got.status, got.placed, got.count,
							got.tail_used, got.tail_frag);
					end
				end
			end
		end
	end

	// end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
